>>> sv/three_level_overload_trip_unit_macros.svh
// ----------------------------------------------------------------------------
// Overload trip unit assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_OVERLOAD_TRIP_UNIT_MACROS_SVH
`define THREE_LEVEL_OVERLOAD_TRIP_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TLOT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("overload trip unit: check failed");

// next-cycle implication, disabled in reset
`define TLOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("overload trip unit: check failed");

`endif

>>> sv/tlot_pkg.sv
// ----------------------------------------------------------------------------
// Overload trip unit package
// Shared types, register map and defaults for the overload trip unit.
// ----------------------------------------------------------------------------
package tlot_pkg;

  // data widths
  localparam int unsigned PWR_W   = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // defaults for top-level parameters
  localparam int unsigned ALARM_DELAY_DEF = 5;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_L1_THRESH   = 3'd1;
  localparam logic [2:0] REG_L1_TRIP     = 3'd2;
  localparam logic [2:0] REG_L2_THRESH   = 3'd3;
  localparam logic [2:0] REG_L2_TRIP     = 3'd4;
  localparam logic [2:0] REG_L3_THRESH   = 3'd5;

  // reset values
  localparam logic [PWR_W-1:0]  L1_THRESH_RST = 16'd110;
  localparam logic [TICK_W-1:0] L1_TRIP_RST   = 16'd600;
  localparam logic [PWR_W-1:0]  L2_THRESH_RST = 16'd120;
  localparam logic [TICK_W-1:0] L2_TRIP_RST   = 16'd60;
  localparam logic [PWR_W-1:0]  L3_THRESH_RST = 16'd150;

  // sample class handed from front to back
  typedef enum logic [2:0] {
    CLS_HOLD  = 3'd0,
    CLS_BELOW = 3'd1,
    CLS_ONE   = 3'd2,
    CLS_TWO   = 3'd3,
    CLS_THREE = 3'd4
  } cls_e;

  localparam int unsigned CLS_W = $bits(cls_e);

  typedef enum logic [1:0] {
    LVL_NONE  = 2'd0,
    LVL_ONE   = 2'd1,
    LVL_TWO   = 2'd2,
    LVL_THREE = 2'd3
  } level_e;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_ONE   = 2'd1,
    EVT_TWO   = 2'd2,
    EVT_THREE = 2'd3
  } event_e;

  // configuration register set
  typedef struct packed {
    logic              enable;
    logic [PWR_W-1:0]  l1_thresh;
    logic [TICK_W-1:0] l1_trip;
    logic [PWR_W-1:0]  l2_thresh;
    logic [TICK_W-1:0] l2_trip;
    logic [PWR_W-1:0]  l3_thresh;
  } cfg_t;

  // one result word
  typedef struct packed {
    event_e evt;
    logic   shutdown;
    logic   alarm_two;
    logic   alarm_one;
    level_e level;
  } res_t;

endpackage

>>> sv/tlot_regs.sv
// ----------------------------------------------------------------------------
// Overload trip unit register file
// APB-style configuration registers, always ready, zero-wait reads.
// ----------------------------------------------------------------------------
module tlot_regs
  import tlot_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:    cfg_d.enable    = pwdata[0];
        REG_L1_THRESH: cfg_d.l1_thresh = pwdata[PWR_W-1:0];
        REG_L1_TRIP:   cfg_d.l1_trip   = pwdata[TICK_W-1:0];
        REG_L2_THRESH: cfg_d.l2_thresh = pwdata[PWR_W-1:0];
        REG_L2_TRIP:   cfg_d.l2_trip   = pwdata[TICK_W-1:0];
        REG_L3_THRESH: cfg_d.l3_thresh = pwdata[PWR_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.l1_thresh <= L1_THRESH_RST;
      cfg_q.l1_trip   <= L1_TRIP_RST;
      cfg_q.l2_thresh <= L2_THRESH_RST;
      cfg_q.l2_trip   <= L2_TRIP_RST;
      cfg_q.l3_thresh <= L3_THRESH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux; thresholds read back as stored 16-bit words
  always_comb begin
    case (reg_idx)
      REG_ENABLE:    prdata = {{(PDATA_W-1){1'b0}}, cfg_q.enable};
      REG_L1_THRESH: prdata = {{(PDATA_W-PWR_W){1'b0}}, cfg_q.l1_thresh};
      REG_L1_TRIP:   prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_q.l1_trip};
      REG_L2_THRESH: prdata = {{(PDATA_W-PWR_W){1'b0}}, cfg_q.l2_thresh};
      REG_L2_TRIP:   prdata = {{(PDATA_W-TICK_W){1'b0}}, cfg_q.l2_trip};
      REG_L3_THRESH: prdata = {{(PDATA_W-PWR_W){1'b0}}, cfg_q.l3_thresh};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/tlot_classify.sv
// ----------------------------------------------------------------------------
// Overload trip unit front end
// Accepts power samples and sorts each one into its overload band.
// ----------------------------------------------------------------------------
module tlot_classify
  import tlot_pkg::*;
(
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [PWR_W-1:0] power_sample_i,
  input  cfg_t             cfg_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output cls_e             q_cls_o
);

  logic signed [PWR_W-1:0] pwr;
  logic ge_l1, ge_l2, ge_l3;

  assign pwr   = $signed(power_sample_i);
  assign ge_l1 = pwr >= $signed(cfg_i.l1_thresh);
  assign ge_l2 = pwr >= $signed(cfg_i.l2_thresh);
  assign ge_l3 = pwr >= $signed(cfg_i.l3_thresh);

  // accept whenever the queue has room
  assign s_axis_tready = ~q_full_i;
  assign q_push_o      = s_axis_tvalid & ~q_full_i;

  // hold when disabled, else band priority: one, two, three, then below
  always_comb begin
    if (!cfg_i.enable)          q_cls_o = CLS_HOLD;
    else if (ge_l1 && !ge_l2)   q_cls_o = CLS_ONE;
    else if (ge_l2 && !ge_l3)   q_cls_o = CLS_TWO;
    else if (ge_l3)             q_cls_o = CLS_THREE;
    else                        q_cls_o = CLS_BELOW;
  end

endmodule

>>> sv/tlot_queue.sv
// ----------------------------------------------------------------------------
// Overload trip unit queue
// Short register FIFO between the classifier and the timer stage.
// ----------------------------------------------------------------------------
module tlot_queue
  import tlot_pkg::*;
#(
  parameter int unsigned WIDTH = CLS_W,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = cnt_q == CNT_W'(DEPTH);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> sv/tlot_timer.sv
// ----------------------------------------------------------------------------
// Overload trip unit back end
// Band timers, latched level, sticky alarms and the registered result word.
// ----------------------------------------------------------------------------
module tlot_timer
  import tlot_pkg::*;
#(
  parameter int unsigned ALARM_DELAY_TICKS = ALARM_DELAY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_empty_i,
  input  cls_e q_cls_i,
  output logic q_pop_o,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output res_t res_o
);

  localparam logic [TICK_W-1:0] DELAY = TICK_W'(ALARM_DELAY_TICKS);
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  logic [TICK_W-1:0] b1_q, b1_d, b2_q, b2_d, t1, t2;
  level_e            lvl_q, lvl_d;
  logic              a1_q, a1_d, a2_q, a2_d;
  logic              pulse;
  event_e            evt;
  logic              vld_q;
  res_t              res_q;

  // take a word when the output slot is free or being drained
  assign q_pop_o = ~q_empty_i & (~vld_q | m_axis_tready);

  // saturating band counts
  assign t1 = (b1_q == TICK_MAX) ? TICK_MAX : b1_q + 1'b1;
  assign t2 = (b2_q == TICK_MAX) ? TICK_MAX : b2_q + 1'b1;

  // per-sample state update
  always_comb begin
    b1_d  = b1_q;
    b2_d  = b2_q;
    lvl_d = lvl_q;
    a1_d  = a1_q;
    a2_d  = a2_q;
    pulse = 1'b0;
    evt   = EVT_NONE;
    case (q_cls_i)
      CLS_HOLD: begin
      end
      CLS_ONE: begin
        b2_d = '0;
        b1_d = t1;
        if (t1 >= DELAY) begin
          lvl_d = LVL_ONE;
          a1_d  = 1'b1;
        end
        if (t1 > cfg_i.l1_trip) begin
          pulse = 1'b1;
          evt   = EVT_ONE;
          b1_d  = '0;
        end
      end
      CLS_TWO: begin
        b1_d = '0;
        b2_d = t2;
        if (t2 >= DELAY) begin
          lvl_d = LVL_TWO;
          a2_d  = 1'b1;
        end
        if (t2 > cfg_i.l2_trip) begin
          pulse = 1'b1;
          evt   = EVT_TWO;
          b2_d  = '0;
        end
      end
      CLS_THREE: begin
        b1_d  = '0;
        b2_d  = '0;
        lvl_d = LVL_THREE;
        pulse = 1'b1;
        evt   = EVT_THREE;
      end
      CLS_BELOW: begin
        b1_d  = '0;
        b2_d  = '0;
        lvl_d = LVL_NONE;
        a1_d  = 1'b0;
        a2_d  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q  <= '0;
      b2_q  <= '0;
      lvl_q <= LVL_NONE;
      a1_q  <= 1'b0;
      a2_q  <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        b1_q  <= b1_d;
        b2_q  <= b2_d;
        lvl_q <= lvl_d;
        a1_q  <= a1_d;
        a2_q  <= a2_d;
        vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q.level     <= lvl_d;
      res_q.alarm_one <= a1_d;
      res_q.alarm_two <= a2_d;
      res_q.shutdown  <= pulse;
      res_q.evt       <= evt;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign res_o         = res_q;

endmodule

>>> sv/three_level_overload_trip_unit.sv
// ----------------------------------------------------------------------------
// Three-level overload trip unit
// Classifies power samples into overload bands and times them to alarm/trip.
// ----------------------------------------------------------------------------
// Each accepted sample waits in the queue until the timer-update stage pops it
// and registers its result word.
// Throughput: one sample per cycle while the result side does not stall, bounded by the single timer-update stage.
// A two-entry queue lets input and output stall independently.
// Reset (rst_ni low, asynchronous): timers, level and alarms clear, queue
// empties, registers return to their defaults (protection disabled).
module three_level_overload_trip_unit
  import tlot_pkg::*;
#(
  parameter int unsigned ALARM_DELAY_TICKS = ALARM_DELAY_DEF,
  parameter int unsigned QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // sample stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [15:0] power_sample
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata   // [1:0] active_level, [2] alarm_one,
                                            // [3] alarm_two, [4] shutdown_pulse,
                                            // [6:5] event_code, [7] zero
);

  cfg_t cfg;
  logic q_push, q_pop, q_full, q_empty;
  cls_e push_cls, pop_cls;
  logic [CLS_W-1:0] pop_bits;
  res_t res;

  tlot_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlot_classify u_classify (
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .power_sample_i (s_axis_tdata[PWR_W-1:0]),
    .cfg_i          (cfg),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cls_o        (push_cls)
  );

  tlot_queue #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cls),
    .pop_i       (q_pop),
    .pop_data_o  (pop_bits),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  assign pop_cls = cls_e'(pop_bits);

  tlot_timer #(
    .ALARM_DELAY_TICKS (ALARM_DELAY_TICKS)
  ) u_timer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_cls_i       (pop_cls),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule

>>> sv/tlot_checker.sv
// ----------------------------------------------------------------------------
// Overload trip unit port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_level_overload_trip_unit_macros.svh"

module tlot_checker
  import tlot_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // shutdown and event code agree
  `TLOT_ASSERT_IMPL(a_evt_pulse, clk_i, rst_ni, m_axis_tvalid,
                    (m_axis_tdata[4] == (m_axis_tdata[6:5] != EVT_NONE)))

  // a level three trip always shows level three latched
  `TLOT_ASSERT_IMPL(a_trip3_level, clk_i, rst_ni,
                    m_axis_tvalid && (m_axis_tdata[6:5] == EVT_THREE),
                    (m_axis_tdata[1:0] == LVL_THREE))

  // level one is only latched together with its alarm
  `TLOT_ASSERT_IMPL(a_lvl1_alarm, clk_i, rst_ni,
                    m_axis_tvalid && (m_axis_tdata[1:0] == LVL_ONE), m_axis_tdata[2])

  // a stalled result holds
  `TLOT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind three_level_overload_trip_unit tlot_checker u_checker (.*);

>>> tb/sv/three_level_overload_trip_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overload trip unit stream checker
// Watches the register port and both streams of the trip unit, keeps its own
// copy of the band timers, level and alarms, and compares every status word
// that leaves the unit, field by field, against the oldest predicted word.
// ----------------------------------------------------------------------------
module three_level_overload_trip_unit_checker
  import tlot_pkg::*;
#(
  parameter int unsigned ALARM_DELAY_TICKS = ALARM_DELAY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port, observed only
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  // sample stream
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [15:0]        s_tdata_i,   // [15:0] power_sample
  // status stream
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [7:0]         m_tdata_i,   // [1:0] active_level, [2] alarm_one,
                                          // [3] alarm_two, [4] shutdown_pulse,
                                          // [6:5] event_code, [7] zero
  output int unsigned        fail_count_o,
  output int unsigned        words_due_o
);

  // predicted register set and protection state
  cfg_t              cfg_q;
  logic [TICK_W-1:0] band_one_ticks_q;
  logic [TICK_W-1:0] band_two_ticks_q;
  level_e            level_q;
  logic              alarm_one_q;
  logic              alarm_two_q;

  // status words still owed by the unit, oldest first
  res_t              due_status_words[$];
  res_t              seen_word;
  res_t              want_word;
  int unsigned       mismatches = 0;

  // band timers stick at the top instead of wrapping
  function automatic logic [TICK_W-1:0] count_up(input logic [TICK_W-1:0] t);
    return (&t) ? t : t + 1'b1;
  endfunction

  // one tick of the protection timers, giving the status word it produces
  task automatic step_trip_timers(input logic signed [PWR_W-1:0] p, output res_t w);
    logic signed [PWR_W-1:0] th_one;
    logic signed [PWR_W-1:0] th_two;
    logic signed [PWR_W-1:0] th_three;
    th_one     = cfg_q.l1_thresh;
    th_two     = cfg_q.l2_thresh;
    th_three   = cfg_q.l3_thresh;
    w.shutdown = 1'b0;
    w.evt      = EVT_NONE;
    if (cfg_q.enable) begin
      if (p >= th_one && p < th_two) begin
        band_one_ticks_q = count_up(band_one_ticks_q);
        band_two_ticks_q = '0;
        if (band_one_ticks_q >= ALARM_DELAY_TICKS) begin
          level_q     = LVL_ONE;
          alarm_one_q = 1'b1;
        end
        if (band_one_ticks_q > cfg_q.l1_trip) begin
          w.shutdown       = 1'b1;
          w.evt            = EVT_ONE;
          band_one_ticks_q = '0;
        end
      end else if (p >= th_two && p < th_three) begin
        band_one_ticks_q = '0;
        band_two_ticks_q = count_up(band_two_ticks_q);
        if (band_two_ticks_q >= ALARM_DELAY_TICKS) begin
          level_q     = LVL_TWO;
          alarm_two_q = 1'b1;
        end
        if (band_two_ticks_q > cfg_q.l2_trip) begin
          w.shutdown       = 1'b1;
          w.evt            = EVT_TWO;
          band_two_ticks_q = '0;
        end
      end else if (p >= th_three) begin
        // immediate trip, alarms untouched
        band_one_ticks_q = '0;
        band_two_ticks_q = '0;
        level_q          = LVL_THREE;
        w.shutdown       = 1'b1;
        w.evt            = EVT_THREE;
      end else begin
        band_one_ticks_q = '0;
        band_two_ticks_q = '0;
        level_q          = LVL_NONE;
        alarm_one_q      = 1'b0;
        alarm_two_q      = 1'b0;
      end
    end
    w.level     = level_q;
    w.alarm_one = alarm_one_q;
    w.alarm_two = alarm_two_q;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // observe handshakes: status words out first, then samples in, then writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     = 1'b0;
      cfg_q.l1_thresh  = L1_THRESH_RST;
      cfg_q.l1_trip    = L1_TRIP_RST;
      cfg_q.l2_thresh  = L2_THRESH_RST;
      cfg_q.l2_trip    = L2_TRIP_RST;
      cfg_q.l3_thresh  = L3_THRESH_RST;
      band_one_ticks_q = '0;
      band_two_ticks_q = '0;
      level_q          = LVL_NONE;
      alarm_one_q      = 1'b0;
      alarm_two_q      = 1'b0;
      due_status_words.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen_word = res_t'(m_tdata_i[6:0]);
        if (due_status_words.size() == 0) begin
          $display("%0t ns: status word 0x%02h with none expected", $time, m_tdata_i);
          mismatches++;
        end else begin
          want_word = due_status_words.pop_front();
          check_field("active_level", want_word.level, seen_word.level);
          check_field("alarm_one", want_word.alarm_one, seen_word.alarm_one);
          check_field("alarm_two", want_word.alarm_two, seen_word.alarm_two);
          check_field("shutdown_pulse", want_word.shutdown, seen_word.shutdown);
          check_field("event_code", want_word.evt, seen_word.evt);
          check_field("pad bit", 0, m_tdata_i[7]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        step_trip_timers(s_tdata_i, want_word);
        due_status_words.push_back(want_word);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_ENABLE:    cfg_q.enable    = pwdata_i[0];
          REG_L1_THRESH: cfg_q.l1_thresh = pwdata_i[PWR_W-1:0];
          REG_L1_TRIP:   cfg_q.l1_trip   = pwdata_i[TICK_W-1:0];
          REG_L2_THRESH: cfg_q.l2_thresh = pwdata_i[PWR_W-1:0];
          REG_L2_TRIP:   cfg_q.l2_trip   = pwdata_i[TICK_W-1:0];
          REG_L3_THRESH: cfg_q.l3_thresh = pwdata_i[PWR_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    words_due_o  <= due_status_words.size();
  end

endmodule

>>> tb/sv/three_level_overload_trip_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overload trip unit testbench
// Programs the trip unit over its register port and streams power samples
// into it: a directed walk through the bands first, then runs of samples aimed
// at each band under several threshold and trip-time settings, with random
// gaps on the sample side and random stalls on the status side.
// ----------------------------------------------------------------------------
module three_level_overload_trip_unit_tb;
  import tlot_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [PDATA_W-1:0] pwdata        = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;

  int unsigned fail_count;
  int unsigned words_due;
  int unsigned stall_cycles   = 0;
  int unsigned send_gap_pct   = 22;
  int unsigned recv_stall_pct = 76;

  // copy of what was programmed, used to aim samples at the bands
  int th_one   = 110;
  int th_two   = 120;
  int th_three = 150;
  int trip_one = 600;
  int trip_two = 60;
  int base;
  int mid;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  three_level_overload_trip_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  three_level_overload_trip_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  // status side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles without a word moving on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // setup then access cycle; written at the edge that sees penable and pready
  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait for every owed status word
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input bit en, input int l1, input int t1, input int l2,
                               input int t2, input int l3);
    drain();
    write_reg(REG_ENABLE, PDATA_W'(en));
    write_reg(REG_L1_THRESH, l1);
    write_reg(REG_L1_TRIP, t1);
    write_reg(REG_L2_THRESH, l2);
    write_reg(REG_L2_TRIP, t2);
    write_reg(REG_L3_THRESH, l3);
    th_one   = l1;
    trip_one = t1;
    th_two   = l2;
    trip_two = t2;
    th_three = l3;
  endtask

  // offer one sample after a random gap, return once it is taken
  task automatic send_sample(input logic [15:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // runs of samples inside one band, at most three longer than the trip time and at
  // most 24 long, mixed with full-range noise and short runs above and below
  task automatic send_band_runs(input int n);
    int left;
    int kind;
    int lo;
    int hi;
    int cap;
    int len;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(9);
      lo   = -32768;
      hi   = 32767;
      cap  = 4;
      case (kind)
        2, 3, 4: begin
          lo  = th_one;
          hi  = th_two - 1;
          cap = (trip_one + 3 < 24) ? trip_one + 3 : 24;
        end
        5, 6, 7: begin
          lo  = th_two;
          hi  = th_three - 1;
          cap = (trip_two + 3 < 24) ? trip_two + 3 : 24;
        end
        8: lo = th_three;
        9: hi = th_one - 1;
        default: ;
      endcase
      // empty band: fall back to noise
      if (hi < lo) begin
        lo  = -32768;
        hi  = 32767;
        cap = 4;
      end
      len = $urandom_range(cap, 1);
      if (len > left) len = left;
      repeat (len) send_sample(16'(lo + $urandom_range(hi - lo)));
      left -= len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // protection off after reset: state held, no trip
    send_sample(16'h7FFF);
    send_sample(16'h8000);

    // band one alarms then trips; band two trip time below the alarm delay
    load_settings(1'b1, 110, 6, 120, 3, 150);
    repeat (7) send_sample(16'd110);
    send_sample(16'd119);
    repeat (6) send_sample(16'd120);
    send_sample(16'd149);
    send_sample(16'd150);
    send_sample(16'h7FFF);
    send_sample(16'd109);
    send_sample(16'h8000);

    // sender gaps light, receiver stalls heavy
    load_settings(1'b1, 110, 8, 120, 4, 150);
    send_band_runs(190);
    base = int'($urandom_range(2000)) - 1000;
    mid  = base + 1 + int'($urandom_range(49));
    load_settings(1'b1, base, $urandom_range(12), mid, $urandom_range(15, 5),
                  mid + 1 + int'($urandom_range(49)));
    send_band_runs(190);

    // sender gaps heavy, receiver stalls light
    send_gap_pct   = 76;
    recv_stall_pct = 22;
    load_settings(1'b1, -32768, 65534, 0, 0, 32767);
    send_band_runs(190);
    // thresholds out of order: bands one and two empty
    load_settings(1'b1, 200, 3, 100, 2, -50);
    send_band_runs(150);

    // no idling on either side
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    load_settings(1'b0, int'($urandom_range(400)) - 200, $urandom_range(20),
                  int'($urandom_range(400)), $urandom_range(20), 32767);
    send_band_runs(100);
    // every sample at or above level three
    load_settings(1'b1, 32767, 0, 32767, 65534, -32768);
    send_band_runs(100);
    base = int'($urandom_range(4000)) - 2000;
    mid  = base + 1 + int'($urandom_range(30));
    load_settings(1'b1, base, $urandom_range(10), mid, $urandom_range(10),
                  mid + 1 + int'($urandom_range(30)));
    send_band_runs(230);

    drain();
    if (fail_count == 0 && words_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> three_level_overload_trip_unit.f
+incdir+sv
sv/tlot_pkg.sv
sv/tlot_regs.sv
sv/tlot_classify.sv
sv/tlot_queue.sv
sv/tlot_timer.sv
sv/three_level_overload_trip_unit.sv
sv/tlot_checker.sv
tb/sv/three_level_overload_trip_unit_checker.sv
tb/sv/three_level_overload_trip_unit_tb.sv
